// File: rtl/pidt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_pkg: shared types and constants
// Field widths, command and mode codes, register indexes, and the structs
// passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package pidt_pkg;

  // reference table depth default and queue sizing
  localparam int TRACK_DEPTH_DEF = 1024;
  localparam int QDEPTH          = 4;
  localparam int QAW             = $clog2(QDEPTH);
  localparam int QCW             = $clog2(QDEPTH + 1);

  // field widths
  localparam int ACTION_W   = 2;
  localparam int COUNT_W    = 16;
  localparam int INDEX_W    = 10;
  localparam int ANGLE_W    = 24;
  localparam int MEAS_W     = 22;
  localparam int DRIVE_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 23;
  localparam int LEN_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // command codes
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HOLD  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TRACK = 2'd3;

  // run modes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRACK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH = 3'd4;

  // configuration register file
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [LEN_W-1:0]         track_length;
  } pidt_cfg_t;

  // one classified beat handed from front to back
  typedef struct packed {
    logic                      regulate;
    logic signed [ANGLE_W-1:0] err;
    logic signed [MEAS_W-1:0]  measured;
    logic [MODE_W-1:0]         mode;
    logic                      done;
  } pidt_item_t;

  // queue status
  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } pidt_qstat_t;

endpackage

// File: rtl/pidt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_front: command decode and reference lookup
// Accepts beats, runs the mode and track position bookkeeping, owns the
// reference table, and hands each beat with its saturated error to the queue.
// ----------------------------------------------------------------------------
module pidt_front #(
  parameter int TRACK_DEPTH = pidt_pkg::TRACK_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic        [pidt_pkg::ACTION_W-1:0]       action,
  input  logic signed [pidt_pkg::COUNT_W-1:0]        encoder_count,
  input  logic        [pidt_pkg::INDEX_W-1:0]        point_index,
  input  logic signed [pidt_pkg::ANGLE_W-1:0]        angle_value,
  input  pidt_pkg::pidt_cfg_t                        cfg,
  input  pidt_pkg::pidt_qstat_t                      qstat,
  output logic                                       push,
  output pidt_pkg::pidt_item_t                       push_item
);
  import pidt_pkg::*;

  localparam int AW = $clog2(TRACK_DEPTH);
  localparam int PW = $clog2(TRACK_DEPTH + 1);
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;
  localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  // architectural state
  logic [MODE_W-1:0]         run_mode;
  logic [MODE_W-1:0]         run_mode_next;
  logic signed [ANGLE_W-1:0] hold_angle;
  logic signed [ANGLE_W-1:0] hold_angle_next;
  logic [PW-1:0]             track_position;
  logic [PW-1:0]             track_position_next;

  // reference table, contents undefined until written
  logic signed [ANGLE_W-1:0] ref_mem [TRACK_DEPTH];

  // stage one registers
  logic                      f1_valid;
  logic                      f1_regulate;
  logic                      f1_use_mem;
  logic signed [ANGLE_W-1:0] f1_ref_hold;
  logic signed [ANGLE_W-1:0] f1_ref_mem;
  logic signed [MEAS_W-1:0]  f1_measured;
  logic [MODE_W-1:0]         f1_mode;
  logic                      f1_done;

  logic                      accept;
  logic [QCW:0]              occupancy;
  logic [CW-1:0]             len_ext;
  logic [CW-1:0]             len_eff;
  logic [PW-1:0]             len_n;
  logic [PW-1:0]             pos;
  logic [PW-1:0]             pos_inc;
  logic                      last_point;
  logic [AW-1:0]             rd_addr;
  logic [IW-1:0]             idx_ext;
  logic                      wr_ok;
  logic [AW-1:0]             wr_addr;
  logic                      mem_we;
  logic signed [MEAS_W-1:0]  cnt_ext;
  logic signed [MEAS_W-1:0]  meas;
  logic                      tick_reg;
  logic                      tick_mem;
  logic                      tick_done;
  logic signed [ANGLE_W-1:0] ref_sel;
  logic signed [ANGLE_W:0]   diff;

  // stall when the queue could not take the beat already in stage one
  assign occupancy = {1'b0, qstat.count} + {{QCW{1'b0}}, f1_valid};
  assign in_stall  = (occupancy >= (QCW+1)'(QDEPTH));
  assign accept    = in_valid && !in_stall;

  // effective track length, clamped to one through the table depth
  always_comb begin
    len_ext = CW'(cfg.track_length);
    if (len_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_ext > CW'(TRACK_DEPTH)) begin
      len_eff = CW'(TRACK_DEPTH);
    end else begin
      len_eff = len_ext;
    end
    len_n = len_eff[PW-1:0];
  end

  // current track point and whether it is the last one
  assign pos        = (track_position >= len_n) ? (len_n - PW'(1)) : track_position;
  assign pos_inc    = pos + PW'(1);
  assign last_point = (pos_inc >= len_n);
  assign rd_addr    = pos[AW-1:0];

  // table write address check
  assign idx_ext = IW'(point_index);
  assign wr_ok   = (idx_ext < IW'(TRACK_DEPTH));
  assign wr_addr = idx_ext[AW-1:0];

  // count times 36 as two shifted adds
  assign cnt_ext = MEAS_W'(encoder_count);
  assign meas    = (cnt_ext <<< 5) + (cnt_ext <<< 2);

  // command decode and next state
  // a finished track goes idle; the hold angle is rewritten by every hold
  // command before a hold tick can use it
  always_comb begin
    run_mode_next       = run_mode;
    hold_angle_next     = hold_angle;
    track_position_next = track_position;
    tick_reg            = 1'b0;
    tick_mem            = 1'b0;
    tick_done           = 1'b0;
    mem_we              = 1'b0;
    unique case (action)
      ACT_TICK: begin
        if (run_mode == MODE_HOLD) begin
          tick_reg = 1'b1;
        end else if (run_mode == MODE_TRACK) begin
          tick_reg            = 1'b1;
          tick_mem            = 1'b1;
          track_position_next = pos_inc;
          if (last_point) begin
            tick_done     = 1'b1;
            run_mode_next = MODE_IDLE;
          end
        end
      end
      ACT_WRITE: begin
        mem_we = wr_ok;
      end
      ACT_HOLD: begin
        hold_angle_next = angle_value;
        run_mode_next   = MODE_HOLD;
      end
      ACT_TRACK: begin
        track_position_next = '0;
        run_mode_next       = MODE_TRACK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= MODE_IDLE;
      hold_angle     <= '0;
      track_position <= '0;
      f1_valid       <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        run_mode       <= run_mode_next;
        hold_angle     <= hold_angle_next;
        track_position <= track_position_next;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_regulate <= tick_reg;
      f1_use_mem  <= tick_mem;
      f1_ref_hold <= hold_angle;
      f1_measured <= (action == ACT_TICK) ? meas : '0;
      f1_mode     <= run_mode_next;
      f1_done     <= tick_done;
    end
  end

  // reference table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      ref_mem[wr_addr] <= angle_value;
    end
    f1_ref_mem <= ref_mem[rd_addr];
  end

  // error = measured - reference, saturated to 24 bits
  assign ref_sel = f1_use_mem ? f1_ref_mem : f1_ref_hold;
  assign diff    = (ANGLE_W+1)'(f1_measured) - (ANGLE_W+1)'(ref_sel);

  always_comb begin
    push_item.regulate = f1_regulate;
    push_item.measured = f1_measured;
    push_item.mode     = f1_mode;
    push_item.done     = f1_done;
    if (diff[ANGLE_W] != diff[ANGLE_W-1]) begin
      push_item.err = diff[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                    : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      push_item.err = diff[ANGLE_W-1:0];
    end
  end

  assign push = f1_valid;

endmodule

// File: rtl/pidt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_queue: decoupling queue
// Small register queue between front and back; the front end only pushes
// when it has reserved a slot, so no full check is needed here.
// ----------------------------------------------------------------------------
module pidt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pidt_pkg::pidt_item_t  push_item,
  input  logic                  pop,
  output pidt_pkg::pidt_item_t  pop_item,
  output pidt_pkg::pidt_qstat_t qstat
);
  import pidt_pkg::*;

  pidt_item_t     slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign pop_item    = slots[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

endmodule

// File: rtl/pidt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_back: PID arithmetic and result register
// Integral clamp and error difference, three gain products, then the
// floor shift and 16-bit saturation into the held drive output.
// ----------------------------------------------------------------------------
module pidt_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pidt_pkg::pidt_cfg_t                   cfg,
  input  pidt_pkg::pidt_qstat_t                 qstat,
  input  pidt_pkg::pidt_item_t                  head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidt_pkg::DRIVE_W-1:0]   drive_current,
  output logic signed [pidt_pkg::MEAS_W-1:0]    measured_angle,
  output logic        [pidt_pkg::MODE_W-1:0]    mode,
  output logic                                  track_done
);
  import pidt_pkg::*;

  localparam int PROD_W = GAIN_W + ANGLE_W;
  localparam int PRDD_W = GAIN_W + ANGLE_W + 1;
  localparam int ACC_W  = PRDD_W + 2;

  logic                      en;

  // integrator state
  logic signed [ANGLE_W-1:0] error_sum;
  logic signed [ANGLE_W-1:0] error_sum_next;
  logic signed [ANGLE_W-1:0] previous_error;

  logic signed [ANGLE_W:0]   sum_raw;
  logic signed [ANGLE_W:0]   lim;
  logic signed [ANGLE_W:0]   edot;

  // stage b1
  logic                      b1_valid;
  logic                      b1_regulate;
  logic signed [ANGLE_W-1:0] b1_err;
  logic signed [ANGLE_W-1:0] b1_sum;
  logic signed [ANGLE_W:0]   b1_edot;
  logic signed [MEAS_W-1:0]  b1_measured;
  logic [MODE_W-1:0]         b1_mode;
  logic                      b1_done;

  // stage b2
  logic                      b2_valid;
  logic                      b2_regulate;
  logic signed [PROD_W-1:0]  b2_p;
  logic signed [PROD_W-1:0]  b2_i;
  logic signed [PRDD_W-1:0]  b2_d;
  logic signed [MEAS_W-1:0]  b2_measured;
  logic [MODE_W-1:0]         b2_mode;
  logic                      b2_done;

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_shr;
  logic signed [DRIVE_W-1:0] drive_sat;

  // whole back pipe moves when the result register is free
  assign en  = !out_valid || !out_stall;
  assign pop = en && !qstat.empty;

  // clamped error sum and error difference
  assign sum_raw = (ANGLE_W+1)'(error_sum) + (ANGLE_W+1)'(head.err);
  assign lim     = $signed({2'b00, cfg.integral_limit});
  assign edot    = (ANGLE_W+1)'(head.err) - (ANGLE_W+1)'(previous_error);

  always_comb begin
    if (sum_raw > lim) begin
      error_sum_next = lim[ANGLE_W-1:0];
    end else if (sum_raw < -lim) begin
      error_sum_next = ANGLE_W'(-lim);
    end else begin
      error_sum_next = sum_raw[ANGLE_W-1:0];
    end
  end

  // floor divide by 256 and saturate
  assign acc     = ACC_W'(b2_p) + ACC_W'(b2_i) + ACC_W'(b2_d);
  assign acc_shr = acc >>> 8;

  always_comb begin
    if (acc_shr > ACC_W'(32767)) begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (acc_shr < -ACC_W'(32768)) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = acc_shr[DRIVE_W-1:0];
    end
  end

  // control state, integrator and held drive
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid       <= 1'b0;
      b2_valid       <= 1'b0;
      out_valid      <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
      drive_current  <= '0;
    end else if (en) begin
      b1_valid  <= pop;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
      if (pop && head.regulate) begin
        error_sum      <= error_sum_next;
        previous_error <= head.err;
      end
      if (b2_valid && b2_regulate) begin
        drive_current <= drive_sat;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      b1_regulate <= head.regulate;
      b1_err      <= head.err;
      b1_sum      <= error_sum_next;
      b1_edot     <= edot;
      b1_measured <= head.measured;
      b1_mode     <= head.mode;
      b1_done     <= head.done;

      b2_regulate <= b1_regulate;
      b2_p        <= cfg.gain_p * b1_err;
      b2_i        <= cfg.gain_i * b1_sum;
      b2_d        <= cfg.gain_d * b1_edot;
      b2_measured <= b1_measured;
      b2_mode     <= b1_mode;
      b2_done     <= b1_done;

      if (b2_valid) begin
        measured_angle <= b2_measured;
        mode           <= b2_mode;
        track_done     <= b2_done;
      end
    end
  end

endmodule

// File: rtl/pid_position_hold_track_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_hold_track_controller: position PID with hold and track modes
// Each beat passes stage one, a queue slot, b1, b2 and the result register.
// Throughput: one beat per cycle while out_stall is low, integrator included.
// A full result register under stall backs up the 4-entry queue, then input.
// Reset clears modes, integrator and drive; the reference table is not cleared.
// ----------------------------------------------------------------------------
module pid_position_hold_track_controller #(
  parameter int TRACK_DEPTH = pidt_pkg::TRACK_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    cfg_write,
  input  logic        [pidt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [pidt_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic        [pidt_pkg::ACTION_W-1:0]    action,
  input  logic signed [pidt_pkg::COUNT_W-1:0]     encoder_count,
  input  logic        [pidt_pkg::INDEX_W-1:0]     point_index,
  input  logic signed [pidt_pkg::ANGLE_W-1:0]     angle_value,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pidt_pkg::DRIVE_W-1:0]     drive_current,
  output logic signed [pidt_pkg::MEAS_W-1:0]      measured_angle,
  output logic        [pidt_pkg::MODE_W-1:0]      mode,
  output logic                                    track_done
);
  import pidt_pkg::*;

  pidt_cfg_t   cfg;
  pidt_qstat_t qstat;
  pidt_item_t  push_item;
  pidt_item_t  head;
  logic        push;
  logic        pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= '0;
      cfg.gain_i         <= '0;
      cfg.gain_d         <= '0;
      cfg.integral_limit <= {LIMIT_W{1'b1}};
      cfg.track_length   <= LEN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_P:       cfg.gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       cfg.gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:       cfg.gain_d         <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT:  cfg.integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_TRACK_LENGTH: cfg.track_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  pidt_front #(
    .TRACK_DEPTH (TRACK_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .encoder_count (encoder_count),
    .point_index   (point_index),
    .angle_value   (angle_value),
    .cfg           (cfg),
    .qstat         (qstat),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  pidt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (head),
    .qstat     (qstat)
  );

  // back end
  pidt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .qstat          (qstat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_current  (drive_current),
    .measured_angle (measured_angle),
    .mode           (mode),
    .track_done     (track_done)
  );

  // a finished trajectory always leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && track_done) |-> (mode == MODE_IDLE))
    else $error("track_done with mode not idle");

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCW'(QDEPTH))
    else $error("queue overflow");

  // an empty queue never holds off the input
  assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !in_stall)
    else $error("input stalled with empty queue");

endmodule

// File: tb/sv/pid_position_hold_track_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_hold_track_controller_tb: self-checking testbench
// Sends control ticks, reference writes, hold and track commands through the
// valid/stall input channel. A cycle-free model of the PID datapath predicts
// each result beat, and every beat on the output channel is checked against
// it field by field. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module pid_position_hold_track_controller_tb;
  import pidt_pkg::*;

  localparam int DEPTH       = TRACK_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 16;
  localparam int RAND_PHASES = 4;
  localparam int PHASE_BEATS = 150;
  localparam int TRAJ_LEN    = 400;

  localparam longint ERR_MIN   = -(longint'(1) <<< (ANGLE_W - 1));
  localparam longint ERR_MAX   = (longint'(1) <<< (ANGLE_W - 1)) - 1;
  localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));
  localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint COUNT_MIN = -(longint'(1) <<< (COUNT_W - 1));
  localparam longint COUNT_MAX = (longint'(1) <<< (COUNT_W - 1)) - 1;
  localparam longint UNITS_PER_COUNT = 36;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [COUNT_W-1:0] count;
    logic [INDEX_W-1:0]        index;
    logic signed [ANGLE_W-1:0] angle;
  } cmd_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [MEAS_W-1:0]  meas;
    logic [MODE_W-1:0]         mode;
    logic                      done;
  } status_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  // dut ports
  logic                        clk           = 1'b0;
  logic                        rst           = 1'b1;
  logic                        cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index     = '0;
  logic [CFG_DATA_W-1:0]       cfg_data      = '0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [ACTION_W-1:0]         action        = '0;
  logic signed [COUNT_W-1:0]   encoder_count = '0;
  logic [INDEX_W-1:0]          point_index   = '0;
  logic signed [ANGLE_W-1:0]   angle_value   = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic signed [DRIVE_W-1:0]   drive_current;
  logic signed [MEAS_W-1:0]    measured_angle;
  logic [MODE_W-1:0]           mode;
  logic                        track_done;

  // controller model: configuration and state
  longint                    kp, ki, kd, sum_limit;
  int unsigned               len_reg;
  logic [MODE_W-1:0]         ctl_mode;
  longint                    hold_pos, err_sum, err_prev, drive_last;
  int unsigned               pt_pos;
  logic signed [ANGLE_W-1:0] ref_pts [DEPTH];
  bit                        pt_written [DEPTH];

  // expected result beats, oldest first
  status_t status_due [$];

  // pacing and bookkeeping
  bit           bursty       = 1'b0;
  int           burst_left   = 0;
  stall_style_t stall_style  = STALL_NONE;
  int           stall_left   = 0;
  int           cyc          = 0;
  int           quiet        = 0;
  int           errors       = 0;
  int           beats_sent   = 0;
  int           beats_checked = 0;
  int           reg_writes   = 0;
  int           trajectories = 0;

  pid_position_hold_track_controller uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .encoder_count  (encoder_count),
    .point_index    (point_index),
    .angle_value    (angle_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_current  (drive_current),
    .measured_angle (measured_angle),
    .mode           (mode),
    .track_done     (track_done)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // controller model
  // ---------------------------------------------------------------------------

  function automatic void model_reset();
    kp         = 0;
    ki         = 0;
    kd         = 0;
    sum_limit  = LIMIT_MAX;
    len_reg    = 1;
    ctl_mode   = MODE_IDLE;
    hold_pos   = 0;
    err_sum    = 0;
    err_prev   = 0;
    pt_pos     = 0;
    drive_last = 0;
    foreach (pt_written[i]) pt_written[i] = 1'b0;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // points actually played: zero acts as one, capped at the table depth
  function automatic int unsigned track_span();
    if (len_reg < 1) return 1;
    if (len_reg > DEPTH) return DEPTH;
    return len_reg;
  endfunction

  // one PID update against a target angle
  function automatic void pid_update(longint meas, longint target);
    longint e, acc;
    e = clip(meas - target, ERR_MIN, ERR_MAX);
    err_sum = clip(err_sum + e, -sum_limit, sum_limit);
    acc = kp * e + ki * err_sum + kd * (e - err_prev);
    // arithmetic shift floors toward minus infinity
    drive_last = clip(acc >>> 8, DRIVE_MIN, DRIVE_MAX);
    err_prev = e;
  endfunction

  // apply one command beat and return the result beat it produces
  function automatic status_t pid_step(cmd_t c);
    status_t     s;
    longint      meas;
    int unsigned n, p;
    meas = 0;
    s.done = 1'b0;
    case (c.action)
      ACT_TICK: begin
        meas = longint'(c.count) * UNITS_PER_COUNT;
        if (ctl_mode == MODE_HOLD) begin
          pid_update(meas, hold_pos);
        end else if (ctl_mode == MODE_TRACK) begin
          n = track_span();
          p = (pt_pos >= n) ? n - 1 : pt_pos;
          pid_update(meas, longint'(ref_pts[p]));
          p++;
          pt_pos = p;
          // last point reached: park on it and go idle
          if (p >= n) begin
            hold_pos = ref_pts[n - 1];
            ctl_mode = MODE_IDLE;
            s.done = 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        ref_pts[c.index] = c.angle;
        pt_written[c.index] = 1'b1;
      end
      ACT_HOLD: begin
        hold_pos = c.angle;
        ctl_mode = MODE_HOLD;
      end
      default: begin
        pt_pos = 0;
        ctl_mode = MODE_TRACK;
      end
    endcase
    s.drive = drive_last[DRIVE_W-1:0];
    s.meas  = meas[MEAS_W-1:0];
    s.mode  = ctl_mode;
    return s;
  endfunction

  // first table entry inside the played span that was never written, or -1
  function automatic int first_gap();
    for (int i = 0; i < track_span(); i++)
      if (!pt_written[i]) return i;
    return -1;
  endfunction

  // angle the next tick regulates to
  function automatic longint current_target();
    int unsigned p;
    if (ctl_mode != MODE_TRACK) return hold_pos;
    p = (pt_pos >= track_span()) ? track_span() - 1 : pt_pos;
    return pt_written[p] ? longint'(ref_pts[p]) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cmd_t mk_cmd(logic [ACTION_W-1:0] act, logic signed [COUNT_W-1:0] cnt,
                                  logic [INDEX_W-1:0] idx, logic signed [ANGLE_W-1:0] ang);
    cmd_t c;
    c.action = act;
    c.count  = cnt;
    c.index  = idx;
    c.angle  = ang;
    return c;
  endfunction

  // encoder count a little off the given angle
  function automatic logic signed [COUNT_W-1:0] count_near(longint target);
    longint v;
    v = target / UNITS_PER_COUNT + longint'(int'($urandom_range(0, 128)) - 64);
    return COUNT_W'(clip(v, COUNT_MIN, COUNT_MAX));
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    if ($urandom_range(0, 3) == 0) return ANGLE_W'($urandom);
    return ANGLE_W'(int'($urandom_range(0, 600000)) - 300000);
  endfunction

  function automatic logic signed [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return LIMIT_MAX;
      default: return LIMIT_W'($urandom_range(0, 200000));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_W'($urandom_range(13, 100));
      default: return LEN_W'($urandom_range(1, 12));
    endcase
  endfunction

  // mostly well-formed traffic with a little noise
  function automatic cmd_t next_cmd();
    cmd_t c;
    int   r;
    int   gap;
    r = $urandom_range(0, 99);
    c = mk_cmd(ACT_TICK, COUNT_W'($urandom), INDEX_W'($urandom_range(0, DEPTH - 1)),
               random_angle());
    if (r < 55) begin
      c.action = ACT_TICK;
    end else if (r < 72) begin
      c.action = ACT_WRITE;
      if ($urandom_range(0, 1) == 0) c.index = INDEX_W'($urandom_range(0, track_span() - 1));
    end else if (r < 82) begin
      c.action = ACT_HOLD;
    end else if (r < 95) begin
      c.action = ACT_TRACK;
    end else begin
      c.action = ACTION_W'($urandom);
    end
    // ticks mostly land near the current target so the loop stays linear
    if (c.action == ACT_TICK && $urandom_range(0, 3) != 0)
      c.count = count_near(current_target());
    // never let a trajectory read a point that was not loaded
    gap = first_gap();
    if (gap >= 0 && (c.action == ACT_TRACK || (c.action == ACT_TICK && ctl_mode == MODE_TRACK)))
    begin
      c.action = ACT_WRITE;
      c.index  = INDEX_W'(gap);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // channel and register tasks
  // ---------------------------------------------------------------------------

  // sender burst/gap pattern
  task automatic pace();
    int gap;
    if (!bursty) return;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // drive one beat and hold it until accepted
  task automatic send_beat(cmd_t c);
    pace();
    in_valid      <= 1'b1;
    action        <= c.action;
    encoder_count <= c.count;
    point_index   <= c.index;
    angle_value   <= c.angle;
    do @(posedge clk); while (in_stall);
    status_due.push_back(pid_step(c));
    beats_sent++;
  endtask

  // stop sending and let every expected beat drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:       kp = longint'($signed(data[GAIN_W-1:0]));
      REG_GAIN_I:       ki = longint'($signed(data[GAIN_W-1:0]));
      REG_GAIN_D:       kd = longint'($signed(data[GAIN_W-1:0]));
      REG_INTEG_LIMIT:  sum_limit = data[LIMIT_W-1:0];
      REG_TRACK_LENGTH: len_reg = data[LEN_W-1:0];
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  // reprogram every register once the block has gone quiet
  task automatic set_config(logic signed [GAIN_W-1:0] p, logic signed [GAIN_W-1:0] i,
                            logic signed [GAIN_W-1:0] d, logic [LIMIT_W-1:0] lim,
                            logic [LEN_W-1:0] len);
    wait_idle();
    write_reg(REG_GAIN_P, {{(CFG_DATA_W - GAIN_W){1'b0}}, p});
    write_reg(REG_GAIN_I, {{(CFG_DATA_W - GAIN_W){1'b0}}, i});
    write_reg(REG_GAIN_D, {{(CFG_DATA_W - GAIN_W){1'b0}}, d});
    write_reg(REG_INTEG_LIMIT, {{(CFG_DATA_W - LIMIT_W){1'b0}}, lim});
    write_reg(REG_TRACK_LENGTH, {{(CFG_DATA_W - LEN_W){1'b0}}, len});
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle ticks, extreme gains, error saturation both ways
  task automatic test_idle_and_saturation();
    set_config(16'sh7fff, 16'sh8000, 16'sh7fff, LIMIT_MAX, 11'd1);
    bursty = 1'b0;
    send_beat(mk_cmd(ACT_TICK, -32768, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 32767, '1, '1));
    send_beat(mk_cmd(ACT_TICK, 0, '0, '0));
    send_beat(mk_cmd(ACT_WRITE, '1, 10'd0, -24'sd8388608));
    send_beat(mk_cmd(ACT_WRITE, '0, 10'd1023, 24'sd8388607));
    send_beat(mk_cmd(ACT_HOLD, 0, '0, 24'sd8388607));
    send_beat(mk_cmd(ACT_TICK, -32768, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 32767, '0, '0));
    send_beat(mk_cmd(ACT_HOLD, 0, '0, -24'sd8388608));
    send_beat(mk_cmd(ACT_TICK, 32767, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 0, '0, '0));
  endtask

  // zero length, zero clamp, restart and hold in the middle of a trajectory
  task automatic test_track_corners();
    set_config(16'sd256, 16'sd64, -16'sd128, '0, '0);
    bursty = 1'b1;
    burst_left = 0;
    send_beat(mk_cmd(ACT_TRACK, 0, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 5, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 7, '0, '0));
    set_config(16'sd256, 16'sd64, -16'sd128, 23'd1000, 11'd3);
    send_beat(mk_cmd(ACT_WRITE, 0, 10'd1, 24'sd1000));
    send_beat(mk_cmd(ACT_WRITE, 0, 10'd2, -24'sd2000));
    send_beat(mk_cmd(ACT_TRACK, 0, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 10, '0, '0));
    send_beat(mk_cmd(ACT_TRACK, 0, '0, '0));
    send_beat(mk_cmd(ACT_TICK, 20, '0, '0));
    send_beat(mk_cmd(ACT_HOLD, 0, '0, 24'sd500));
    send_beat(mk_cmd(ACT_TICK, 40, '0, '0));
    send_beat(mk_cmd(ACT_TRACK, 0, '0, '0));
    repeat (3) send_beat(mk_cmd(ACT_TICK, 30, '0, '0));
  endtask

  // load a long stretch of the table and play it to the end
  task automatic test_full_trajectory();
    set_config(16'sd300, 16'sd8, 16'sd40, LIMIT_W'($urandom_range(1000, 500000)),
               LEN_W'(TRAJ_LEN));
    bursty = 1'b1;
    burst_left = 0;
    for (int i = 0; i < TRAJ_LEN; i++)
      if (!pt_written[i])
        send_beat(mk_cmd(ACT_WRITE, COUNT_W'($urandom), INDEX_W'(i),
                         ANGLE_W'(int'($urandom_range(0, 400000)) - 200000)));
    send_beat(mk_cmd(ACT_TRACK, COUNT_W'($urandom), INDEX_W'($urandom),
                     ANGLE_W'($urandom)));
    repeat (TRAJ_LEN) send_beat(mk_cmd(ACT_TICK, count_near(current_target()), '0, '0));
    send_beat(mk_cmd(ACT_TICK, count_near(current_target()), '0, '0));
  endtask

  // random phases, each with its own settings and pacing
  task automatic test_random_mix();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_config(random_gain(), random_gain(), random_gain(), random_limit(), random_length());
      bursty = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      repeat (PHASE_BEATS) send_beat(next_cmd());
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // receiver stall pattern, switching style now and then
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_left  <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
      default:     out_stall <= ((cyc % 7) < 3);
    endcase
  end

  function automatic void compare(string field, logic signed [63:0] want_v,
                                  logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
      errors++;
    end
  endfunction

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, drive_current %0d mode %0d",
                 $time, drive_current, mode);
        errors++;
      end else begin
        want = status_due.pop_front();
        compare("drive_current", want.drive, drive_current);
        compare("measured_angle", want.meas, measured_angle);
        compare("mode", {62'd0, want.mode}, {62'd0, mode});
        compare("track_done", {63'd0, want.done}, {63'd0, track_done});
        if (want.done) trajectories++;
        beats_checked++;
      end
    end
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
               $time, quiet, status_due.size());
      $display("pid_position_hold_track_controller_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_saturation();
    test_track_corners();
    test_full_trajectory();
    test_random_mix();
    wait_idle();
    if (status_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, status_due.size());
      errors++;
    end
    $display("covered %0d beats, %0d results checked, %0d register writes, %0d trajectories",
             beats_sent, beats_checked, reg_writes, trajectories);
    $display("incl. saturation corners, zero lengths, mid-track restarts, a %0d-point track",
             TRAJ_LEN);
    if (errors == 0) begin
      $display("pid_position_hold_track_controller_tb OK");
    end else begin
      $display("pid_position_hold_track_controller_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pidt_pkg.sv
rtl/pidt_front.sv
rtl/pidt_queue.sv
rtl/pidt_back.sv
rtl/pid_position_hold_track_controller.sv
tb/sv/pid_position_hold_track_controller_tb.sv
